// ===== rtl/dq_pkg.sv =====
// ---------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue.
// ---------------------------------------------------------------------------
package dq_pkg;

	localparam int DQ_DEPTH     = 16;
	localparam int DQ_WORD_W    = 32;
	// widest count and index over the supported depth range (1 to 64)
	localparam int DQ_CNT_MAX_W = 7;
	localparam int DQ_IDX_MAX_W = 6;

	typedef enum logic [2:0] {
		ACT_PUSH_BACK  = 3'd0,
		ACT_PUSH_FRONT = 3'd1,
		ACT_POP_BACK   = 3'd2,
		ACT_POP_FRONT  = 3'd3,
		ACT_LIST       = 3'd4
	} dq_action_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_UNDERFLOW  = 2'd1,
		STAT_OVERFLOW   = 2'd2,
		STAT_EMPTY_LIST = 2'd3
	} dq_status_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EMIT = 1'b1
	} dq_state_t;

	// controller state as seen by the top level
	typedef struct packed {
		dq_state_t                 state;
		logic [DQ_CNT_MAX_W-1:0]   count;
		logic [DQ_IDX_MAX_W-1:0]   front;
	} dq_stat_t;

endpackage

// ===== rtl/dq_ram.sv =====
// ---------------------------------------------------------------------------
// dq_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/dq_ctrl.sv =====
// ---------------------------------------------------------------------------
// dq_ctrl
// Queue pointers, action decode, RAM sequencing and the result register.
// ---------------------------------------------------------------------------
module dq_ctrl #(
	parameter int DEPTH = dq_pkg::DQ_DEPTH,
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [2:0]                    action,
	input  logic signed [dq_pkg::DQ_WORD_W-1:0] value,
	// result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [dq_pkg::DQ_WORD_W-1:0] word,
	output logic [1:0]                    status,
	output logic                          last,
	// RAM port
	output logic                          wr_en,
	output logic [IDX_W-1:0]              wr_addr,
	output logic [dq_pkg::DQ_WORD_W-1:0]  wr_data,
	output logic                          rd_en,
	output logic [IDX_W-1:0]              rd_addr,
	input  logic [dq_pkg::DQ_WORD_W-1:0]  rd_data,
	// observation
	output dq_pkg::dq_stat_t              stat
);

	import dq_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = IDX_W + 1;

	dq_state_t             state_q, state_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [IDX_W-1:0]      front_q, front_d;
	logic [IDX_W-1:0]      idx_q, idx_d;
	logic [CNT_W-1:0]      left_q, left_d;
	logic                  use_mem_q, use_mem_d;
	dq_status_t            stat_q, stat_d;

	logic                  out_valid_q;
	logic [DQ_WORD_W-1:0]  word_q;
	logic [1:0]            status_q;
	logic                  last_q;

	dq_action_t            act;
	logic                  in_acc, slot_free, emit, full, empty;
	logic [SUM_W-1:0]      off, sum;
	logic [IDX_W-1:0]      slot, front_dec, front_inc;

	assign act       = dq_action_t'(action);
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);

	// ring position of front + offset; both terms are below DEPTH whenever the slot is used
	assign sum  = SUM_W'(front_q) + off;
	assign slot = (sum >= SUM_W'(DEPTH)) ? IDX_W'(sum - SUM_W'(DEPTH)) : IDX_W'(sum);

	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
	assign front_inc = (front_q == IDX_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (action <= 3'(ACT_LIST))) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free && (left_q == '0)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and datapath control
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		emit      = 1'b0;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		off       = '0;
		count_d   = count_q;
		front_d   = front_q;
		idx_d     = idx_q;
		left_d    = left_q;
		use_mem_d = use_mem_q;
		stat_d    = stat_q;
		wr_addr   = slot;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					left_d    = '0;
					use_mem_d = 1'b0;
					stat_d    = STAT_OK;
					case (act)
						ACT_PUSH_BACK: begin
							off = SUM_W'(count_q);
							if (full) begin
								stat_d = STAT_OVERFLOW;
							end else begin
								wr_en   = 1'b1;
								count_d = count_q + 1'b1;
							end
						end
						ACT_PUSH_FRONT: begin
							wr_addr = front_dec;
							if (full) begin
								stat_d = STAT_OVERFLOW;
							end else begin
								wr_en   = 1'b1;
								front_d = front_dec;
								count_d = count_q + 1'b1;
							end
						end
						ACT_POP_BACK: begin
							off = SUM_W'(count_q - 1'b1);
							if (empty) begin
								stat_d = STAT_UNDERFLOW;
							end else begin
								rd_en     = 1'b1;
								use_mem_d = 1'b1;
								count_d   = count_q - 1'b1;
							end
						end
						ACT_POP_FRONT: begin
							if (empty) begin
								stat_d = STAT_UNDERFLOW;
							end else begin
								rd_en     = 1'b1;
								use_mem_d = 1'b1;
								front_d   = front_inc;
								count_d   = count_q - 1'b1;
							end
						end
						ACT_LIST: begin
							if (empty) begin
								stat_d = STAT_EMPTY_LIST;
							end else begin
								rd_en     = 1'b1;
								use_mem_d = 1'b1;
								idx_d     = IDX_W'(1);
								left_d    = count_q - 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			ST_EMIT: begin
				off = SUM_W'(idx_q);
				if (slot_free) begin
					emit = 1'b1;
					// fetch the next listed entry while this beat goes out
					if (left_q != '0) begin
						rd_en  = 1'b1;
						idx_d  = idx_q + 1'b1;
						left_d = left_q - 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign rd_addr = slot;
	assign wr_data = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			front_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			front_q <= front_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		left_q    <= left_d;
		use_mem_q <= use_mem_d;
		stat_q    <= stat_d;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			word_q   <= use_mem_q ? rd_data : '0;
			status_q <= stat_q;
			last_q   <= (left_q == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign word      = word_q;
	assign status    = status_q;
	assign last      = last_q;

	assign stat.state = state_q;
	assign stat.count = DQ_CNT_MAX_W'(count_q);
	assign stat.front = DQ_IDX_MAX_W'(front_q);

endmodule

// ===== rtl/double_ended_queue_top.sv =====
// ---------------------------------------------------------------------------
// double_ended_queue_top
// Bounded deque of signed 32-bit words in a ring RAM of DEPTH entries. Each
// item is a push or pop at either end, or a listing of the contents front to
// back. One item is worked at a time: a push or pop is accepted, then its
// status beat goes out; a listing of N entries gives N beats, one RAM read per
// entry through the single read port of the ring RAM. A finished beat waits
// in the output register while the next item is accepted.
// ---------------------------------------------------------------------------
module double_ended_queue_top #(
	parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [2:0]                          action,
	input  logic signed [dq_pkg::DQ_WORD_W-1:0] value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [dq_pkg::DQ_WORD_W-1:0] word,
	output logic [1:0]                          status,
	output logic                                last
);

	import dq_pkg::*;

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                  wr_en, rd_en;
	logic [IDX_W-1:0]      wr_addr, rd_addr;
	logic [DQ_WORD_W-1:0]  wr_data, rd_data;
	dq_stat_t              stat;

	dq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.word      (word),
		.status    (status),
		.last      (last),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.stat      (stat)
	);

	dq_ram #(
		.WIDTH (DQ_WORD_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= DQ_CNT_MAX_W'(DEPTH))
		else $error("fill count beyond depth");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (action == ACT_POP_BACK || action == ACT_POP_FRONT)
		 && stat.count != '0)
		|=> stat.count == $past(stat.count) - 1'b1)
		else $error("pop did not shrink the queue");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && (action == ACT_PUSH_BACK || action == ACT_PUSH_FRONT)
		 && stat.count == DQ_CNT_MAX_W'(DEPTH))
		|=> $stable(stat.count) && $stable(stat.front))
		else $error("push on full queue changed state");

	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(stat.state == ST_EMIT) |=> $stable(stat.front) && $stable(stat.count))
		else $error("pointers moved while results were going out");

endmodule
